// ===== hw/rtl/lru_kv_pkg.sv =====
// shared types and constants for the lru key-value cache
package lru_kv_pkg;

    localparam int CAP_W   = 5;
    localparam int VALUE_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic signed [VALUE_W-1:0] lru_kv_value_t;

    // read value returned by a get that misses
    localparam lru_kv_value_t MISS_VALUE = -32'sd1;

    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } lru_kv_req_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_APPLY = 1'b1
    } lru_kv_state_t;

    // control broadcast to every cell of the recency chain
    typedef struct packed {
        logic capture;  // register the key compare
        logic shift;    // move entries one place older up to the stop index
    } lru_kv_cell_ctl_t;

endpackage

// ===== hw/rtl/lru_kv_cell.sv =====
// one entry of the recency-ordered chain: key, value, valid and match flag
module lru_kv_cell import lru_kv_pkg::*; #(
    parameter int KEY_BITS = 16,
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lru_kv_cell_ctl_t      ctl,
    input  logic [IDX_W-1:0]      stop_idx,
    input  logic [KEY_BITS-1:0]   probe_key,
    input  logic                  prev_valid,
    input  logic [KEY_BITS-1:0]   prev_key,
    input  lru_kv_value_t         prev_value,
    output logic                  valid,
    output logic [KEY_BITS-1:0]   key,
    output lru_kv_value_t         value,
    output logic                  match
);

    logic                valid_reg;
    logic                valid_next;
    logic                match_reg;
    logic                match_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    lru_kv_value_t       value_reg;
    lru_kv_value_t       value_next;
    logic                take;

    // cells from the head down to the stop index take their neighbor's entry
    assign take = ctl.shift && (IDX_W'(CELL_IDX) <= stop_idx);

    assign valid_next = take ? prev_valid : valid_reg;
    assign key_next   = take ? prev_key   : key_reg;
    assign value_next = take ? prev_value : value_reg;
    assign match_next = ctl.capture ? (valid_reg && (key_reg == probe_key)) : match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;
    assign match = match_reg;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// top level of the fully associative lru key-value cache
//
// The cache holds up to ENTRIES key-value pairs in a row of cells kept in
// recency order: cell 0 is the most recent entry, and each cell further down
// is one step older, so the valid entries always fill cells 0 to count-1.
// Each request has an accept cycle and a resolve cycle: in the accept cycle
// every cell compares its key with the request key and stores a match flag,
// and in the resolve cycle the request is resolved and, unless a get misses,
// the chain shifts by one place (each cell takes its neighbor's entry) from
// the head down to the hit cell, the oldest entry or the first free cell,
// while the new or refreshed entry enters at cell 0. The resolve cycle waits
// while an earlier result is still held on the m_ side. The capacity register
// can be written at any time through the cfg channel, which is always ready;
// write it only while no request is in flight. The entries are invalid after
// reset with no clearing pass.
module lru_key_value_cache import lru_kv_pkg::*; #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // request items
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic                                       s_tuser,  // req_type
    input  logic [((KEY_BITS+VALUE_W+7)/8)*8-1:0]      s_tdata,  // key, value
    // result items
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [1:0]                                 m_tuser,  // hit, evicted
    output logic [((KEY_BITS+VALUE_W+7)/8)*8-1:0]      m_tdata,  // read_value, evicted_key
    // capacity register writes
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [CAP_W-1:0]                           cfg_data
);

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int M_DATA_W = ((KEY_BITS + VALUE_W + 7) / 8) * 8;

    // control state
    lru_kv_state_t       state_reg;
    lru_kv_state_t       state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CAP_W-1:0]    capacity_reg;
    logic [CAP_W-1:0]    capacity_next;
    logic                m_valid_reg;
    logic                m_valid_next;

    // held request
    lru_kv_req_t         req_type_reg;
    logic [KEY_BITS-1:0] req_key_reg;
    lru_kv_value_t       req_value_reg;

    // held result
    logic                out_hit_reg;
    logic                out_evicted_reg;
    lru_kv_value_t       out_value_reg;
    logic [KEY_BITS-1:0] out_evk_reg;

    // chain of cells
    logic                cell_valid [ENTRIES];
    logic [KEY_BITS-1:0] cell_key   [ENTRIES];
    lru_kv_value_t       cell_value [ENTRIES];
    logic                cell_match [ENTRIES];
    lru_kv_cell_ctl_t    cell_ctl;
    logic [IDX_W-1:0]    stop_idx;
    lru_kv_value_t       head_value;

    // handshakes
    logic                in_accept;
    logic                out_free;
    logic                fire;

    // gathered from the cells
    logic                hit_any;
    logic [IDX_W-1:0]    hit_idx;
    lru_kv_value_t       hit_value;
    logic [KEY_BITS-1:0] oldest_key;
    logic [CNT_W-1:0]    count_m1;
    logic [IDX_W-1:0]    last_idx;

    // resolution of the held request
    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    eff_cap;
    logic                full;
    logic                shift_en;
    logic                count_inc;
    logic                res_evicted;
    lru_kv_value_t       res_value;
    logic [KEY_BITS-1:0] res_evk;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign fire      = (state_reg == ST_APPLY) && out_free;
    assign cfg_ready = 1'b1;

    // compare in the accept cycle, shift in the resolve cycle
    assign cell_ctl.capture = in_accept;
    assign cell_ctl.shift   = fire && shift_en;

    // new entry at the head: the key of the request, its value for a put and
    // the stored value for a get hit
    assign head_value = (req_type_reg == REQ_PUT) ? req_value_reg : hit_value;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        if (i == 0) begin : g_head
            lru_kv_cell #(
                .KEY_BITS (KEY_BITS),
                .IDX_W    (IDX_W),
                .CELL_IDX (i)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (cell_ctl),
                .stop_idx   (stop_idx),
                .probe_key  (s_tdata[KEY_BITS-1:0]),
                .prev_valid (1'b1),
                .prev_key   (req_key_reg),
                .prev_value (head_value),
                .valid      (cell_valid[i]),
                .key        (cell_key[i]),
                .value      (cell_value[i]),
                .match      (cell_match[i])
            );
        end else begin : g_body
            lru_kv_cell #(
                .KEY_BITS (KEY_BITS),
                .IDX_W    (IDX_W),
                .CELL_IDX (i)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (cell_ctl),
                .stop_idx   (stop_idx),
                .probe_key  (s_tdata[KEY_BITS-1:0]),
                .prev_valid (cell_valid[i-1]),
                .prev_key   (cell_key[i-1]),
                .prev_value (cell_value[i-1]),
                .valid      (cell_valid[i]),
                .key        (cell_key[i]),
                .value      (cell_value[i]),
                .match      (cell_match[i])
            );
        end
    end

    // oldest valid entry sits at cell count-1
    assign count_m1 = count_reg - CNT_W'(1);
    assign last_idx = count_m1[IDX_W-1:0];

    // keys are unique among valid cells, so at most one match flag is set
    always_comb begin
        hit_any    = 1'b0;
        hit_idx    = '0;
        hit_value  = '0;
        oldest_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_any   = hit_any | cell_match[i];
            hit_idx   = hit_idx | (cell_match[i] ? IDX_W'(i) : IDX_W'(0));
            hit_value = hit_value | (cell_match[i] ? cell_value[i] : lru_kv_value_t'(0));
            oldest_key = oldest_key |
                ((IDX_W'(i) == last_idx) ? cell_key[i] : KEY_BITS'(0));
        end
    end

    // capacity of zero acts as one, above the row size as the row size
    always_comb begin
        cap_ext = CMP_W'(capacity_reg);
        if (cap_ext == CMP_W'(0)) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        full = CMP_W'(count_reg) >= eff_cap;
    end

    always_comb begin
        shift_en    = 1'b0;
        stop_idx    = hit_idx;
        count_inc   = 1'b0;
        res_evicted = 1'b0;
        res_value   = '0;
        res_evk     = '0;
        case (req_type_reg)
            REQ_GET: begin
                if (hit_any) begin
                    shift_en  = 1'b1;
                    res_value = hit_value;
                end else begin
                    res_value = MISS_VALUE;
                end
            end
            REQ_PUT: begin
                if (hit_any) begin
                    shift_en = 1'b1;
                end else if (full) begin
                    // oldest entry drops off the end of the used part
                    shift_en    = 1'b1;
                    stop_idx    = last_idx;
                    res_evicted = 1'b1;
                    res_evk     = oldest_key;
                end else begin
                    // first free cell receives the entry ahead of it
                    shift_en  = 1'b1;
                    stop_idx  = count_reg[IDX_W-1:0];
                    count_inc = 1'b1;
                end
            end
            default: begin
                shift_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        capacity_next = capacity_reg;
        m_valid_next  = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            capacity_next = cfg_data;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (fire) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    if (count_inc) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            capacity_reg <= capacity_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            req_type_reg  <= lru_kv_req_t'(s_tuser);
            req_key_reg   <= s_tdata[KEY_BITS-1:0];
            req_value_reg <= lru_kv_value_t'(s_tdata[KEY_BITS+VALUE_W-1:KEY_BITS]);
        end
        if (fire) begin
            out_hit_reg     <= hit_any;
            out_evicted_reg <= res_evicted;
            out_value_reg   <= res_value;
            out_evk_reg     <= res_evk;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {out_evicted_reg, out_hit_reg};
    assign m_tdata  = M_DATA_W'({out_evk_reg, out_value_reg});

endmodule

// ===== hw/rtl/lru_kv_checker.sv =====
// port-level checks for the lru key-value cache and their bind
module lru_kv_checker import lru_kv_pkg::*; #(
    parameter int KEY_BITS = 16
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [1:0]                            m_tuser,
    input logic [((KEY_BITS+VALUE_W+7)/8)*8-1:0] m_tdata
);

    // a held result keeps its fields
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // m_tvalid is expected on the result port after every accepted item
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result after accepted item");

    // an eviction only happens on a put that missed
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata[VALUE_W-1:0] == '0))
        else $error("eviction reported with hit or read value");

    // evicted key is zero unless an entry was removed
    a_evk_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> (m_tdata[KEY_BITS+VALUE_W-1:VALUE_W] == '0))
        else $error("evicted key without eviction");

endmodule

bind lru_key_value_cache lru_kv_checker #(.KEY_BITS(KEY_BITS)) u_lru_kv_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench for the lru key-value cache
`timescale 1ns / 100ps

module testbench import lru_kv_pkg::*; ();

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 16;
    localparam int DATA_W  = ((KEY_W + VALUE_W + 7) / 8) * 8;

    typedef struct {
        lru_kv_req_t   kind;
        logic [KEY_W-1:0] key;
        lru_kv_value_t value;
    } cache_request_t;

    typedef struct {
        logic             hit;
        lru_kv_value_t    read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_response_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic              s_tuser   = 1'b0;   // req_type
    logic [DATA_W-1:0] s_tdata   = '0;     // key, value
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [1:0]        m_tuser;            // hit, evicted
    logic [DATA_W-1:0] m_tdata;            // read_value, evicted_key
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data  = '0;

    // requests still to be driven, and responses predicted but not yet seen
    cache_request_t  request_backlog[$];
    cache_response_t pending_results[$];
    cache_request_t  active_request;
    bit              no_idle = 1'b0;
    int              error_count = 0;

    // shadow copy of the cache contents
    logic [KEY_W-1:0] shadow_key[ENTRIES];
    lru_kv_value_t    shadow_value[ENTRIES];
    bit               shadow_valid[ENTRIES];
    int unsigned      shadow_rank[ENTRIES];
    int unsigned      shadow_count = 0;
    logic [CAP_W-1:0] capacity_setting = CAP_RESET;

    lru_key_value_cache #(
        .ENTRIES (ENTRIES),
        .KEY_BITS(KEY_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned effective_capacity(logic [CAP_W-1:0] cap);
        if (cap == 0) return 1;
        if (cap > ENTRIES) return ENTRIES;
        return 32'(cap);
    endfunction

    // entry s becomes most recent, entries younger than it age by one
    function automatic void make_most_recent(int s);
        int unsigned old_rank;
        old_rank = shadow_rank[s];
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != s && shadow_valid[i] && shadow_rank[i] < old_rank)
                shadow_rank[i]++;
        end
        shadow_rank[s] = 0;
    endfunction

    // applies one request to the shadow cache and returns its response
    function automatic cache_response_t predict_access(cache_request_t req);
        cache_response_t rsp;
        int slot;
        int victim;
        int free_slot;
        rsp = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
        slot = -1;
        victim = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && shadow_valid[i] && shadow_key[i] == req.key)
                slot = i;
        end
        if (req.kind == REQ_GET) begin
            if (slot >= 0) begin
                rsp.hit = 1'b1;
                rsp.read_value = shadow_value[slot];
                make_most_recent(slot);
            end else begin
                rsp.read_value = MISS_VALUE;
            end
        end else if (slot >= 0) begin
            rsp.hit = 1'b1;
            shadow_value[slot] = req.value;
            make_most_recent(slot);
        end else if (shadow_count >= effective_capacity(capacity_setting)) begin
            // store full: the oldest entry is replaced in place
            for (int i = 0; i < ENTRIES; i++) begin
                if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                    victim = i;
            end
            if (victim >= 0) begin
                rsp.evicted = 1'b1;
                rsp.evicted_key = shadow_key[victim];
                shadow_key[victim] = req.key;
                shadow_value[victim] = req.value;
                make_most_recent(victim);
            end
        end else begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!shadow_valid[i]) free_slot = i;
            end
            if (free_slot >= 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (shadow_valid[i]) shadow_rank[i]++;
                end
                shadow_valid[free_slot] = 1'b1;
                shadow_key[free_slot] = req.key;
                shadow_value[free_slot] = req.value;
                shadow_rank[free_slot] = 0;
                shadow_count++;
            end
        end
        return rsp;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // request driver: valid holds until the item is taken
    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                pending_results.insert(pending_results.size(), predict_access(active_request));
                next_valid = 1'b0;
            end
            if (!next_valid && request_backlog.size() != 0 &&
                (no_idle || $urandom_range(99) >= 10)) begin
                active_request = request_backlog[0];
                request_backlog.delete(0);
                s_tuser <= active_request.kind;
                s_tdata <= {active_request.value, active_request.key};
                next_valid = 1'b1;
            end
            s_tvalid <= next_valid;
        end
    end

    // result sink with random stalls
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 10);
    end

    // result monitor
    always @(posedge aclk) begin
        cache_response_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual tuser %b tdata %h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                compare_field("hit", want.hit, m_tuser[0]);
                compare_field("evicted", want.evicted, m_tuser[1]);
                compare_field("read_value", want.read_value, m_tdata[31:0]);
                compare_field("evicted_key", want.evicted_key, m_tdata[47:32]);
            end
        end
    end

    task automatic push_request(lru_kv_req_t kind, logic [KEY_W-1:0] key,
                                lru_kv_value_t value);
        cache_request_t req;
        req.kind = kind;
        req.key = key;
        req.value = value;
        request_backlog.insert(request_backlog.size(), req);
    endtask

    // waits until every item has been taken and answered, checked once the edge has settled
    task automatic wait_quiet();
        do begin
            @(posedge aclk);
            #1;
        end while (request_backlog.size() != 0 || s_tvalid || pending_results.size() != 0);
    endtask

    task automatic write_capacity(int unsigned cap);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= cap[CAP_W-1:0];
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        capacity_setting = cfg_data;
        cfg_valid <= 1'b0;
    endtask

    // random traffic over a small key pool so that hits and evictions are common
    task automatic random_phase(int n_items);
        logic [KEY_W-1:0] pool[$];
        int pool_size;
        logic [KEY_W-1:0] key;
        pool_size = effective_capacity(capacity_setting) + $urandom_range(1, 8);
        for (int i = 0; i < pool_size; i++)
            pool.insert(pool.size(), KEY_W'($urandom_range(16'hFFFF)));
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 85) key = pool[$urandom_range(pool_size - 1)];
            else key = KEY_W'($urandom_range(16'hFFFF));
            push_request(lru_kv_req_t'($urandom_range(1)), key, $urandom);
        end
    endtask

    initial begin
        int unsigned cap_plan[8];
        cap_plan = '{16, 1, 31, 0, 4, 2, 0, 16};
        cap_plan[6] = $urandom_range(3, 15);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset capacity: miss on an empty store, key and value extremes, update
        push_request(REQ_GET, 16'h0000, 32'sh1234_5678);
        push_request(REQ_PUT, 16'h0000, 32'sh8000_0000);
        push_request(REQ_PUT, 16'hFFFF, 32'sh7FFF_FFFF);
        push_request(REQ_PUT, 16'h0001, 32'sh0000_0000);
        push_request(REQ_GET, 16'hFFFF, 32'sh0000_0000);
        push_request(REQ_GET, 16'h0000, 32'shFFFF_FFFF);
        push_request(REQ_PUT, 16'h0000, 32'shFFFF_FFFF);
        push_request(REQ_GET, 16'h0005, 32'sh0000_0000);
        push_request(REQ_GET, 16'h0001, 32'sh5555_5555);
        wait_quiet();

        // capacity lowered below the entry count: each new key evicts one
        write_capacity(2);
        push_request(REQ_PUT, 16'h0007, 32'sh0000_0007);
        push_request(REQ_PUT, 16'h0008, 32'shAAAA_AAAA);
        push_request(REQ_GET, 16'h0007, 32'sh0000_0000);
        push_request(REQ_PUT, 16'h0007, 32'sh0000_0077);
        wait_quiet();

        // zero capacity behaves as one
        write_capacity(0);
        push_request(REQ_PUT, 16'h0009, 32'sh0000_0009);
        push_request(REQ_GET, 16'h0008, 32'sh0000_0000);
        push_request(REQ_PUT, 16'h000A, 32'sh0000_000A);
        wait_quiet();

        // capacity above the entry count behaves as full size
        write_capacity(31);
        push_request(REQ_PUT, 16'h000B, 32'sh0000_000B);
        push_request(REQ_PUT, 16'hAAAA, 32'sh5555_5555);
        push_request(REQ_PUT, 16'h5555, 32'shAAAA_AAAA);
        push_request(REQ_GET, 16'hAAAA, 32'sh0000_0000);
        push_request(REQ_GET, 16'h5555, 32'sh0000_0000);
        wait_quiet();

        foreach (cap_plan[ph]) begin
            write_capacity(cap_plan[ph]);
            // one phase runs without any idle cycles on either side
            no_idle = (ph == 3);
            random_phase(100);
            wait_quiet();
        end
        no_idle = 1'b0;

        repeat (10) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[lru_key_value_cache] OK");
        end else begin
            $display("[lru_key_value_cache] ERROR");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("[lru_key_value_cache] ERROR");
        $finish;
    end

endmodule
